### rtl/core/rsfd_pkg.sv
// shared constants for the silence-delimited frame receiver
`timescale 1ns / 1ps

package rsfd_pkg;

  // default store size in bytes per frame buffer
  localparam int FRAME_BYTES_DEF = 64;

  // configuration register indexes
  localparam logic CFG_GAP_TICKS     = 1'b0;
  localparam logic CFG_CONFIRM_TICKS = 1'b1;

  // configuration reset values
  localparam logic [7:0] GAP_TICKS_RST     = 8'd21;
  localparam logic [7:0] CONFIRM_TICKS_RST = 8'd29;

  // fixed field widths
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;
  localparam int TICK_W = 8;

  // event kinds on the input channel
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_BYTE = 1'b1;

endpackage

### rtl/core/rtu_silence_frame_delimiter_top.sv
// top level of the silence-delimited serial frame receiver
`timescale 1ns / 1ps

// Each request is one timer tick or one received byte and is taken in a single
// cycle. Bytes go into one of two frame buffers; after gap_ticks silent ticks
// and a further confirm_ticks silent ticks the frame is queued and read out at
// one byte per cycle while out_ready is high, through the store's single read
// port, with frame_length on every byte and last on the final one. A byte in
// the confirm wait drops the frame, and bytes past FRAME_BYTES are dropped.
// Input requests stall only while two finished frames both wait for readout.

module rtu_silence_frame_delimiter_top import rsfd_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [TICK_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              func,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] frame_byte,
  output logic [LEN_W-1:0]  frame_length,
  output logic              last
);

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int CW = $clog2(FRAME_BYTES + 1);

  logic              wr_en, rd_en;
  logic [AW:0]       wr_addr, rd_addr;
  logic [BYTE_W-1:0] wr_data;
  logic              push, push_bank, pop;
  logic [CW-1:0]     push_len, head_len;
  logic              q_full, q_empty, head_bank;

  rsfd_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .rx_byte   (rx_byte),
    .q_full    (q_full),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .push      (push),
    .push_bank (push_bank),
    .push_len  (push_len)
  );

  rsfd_queue #(.FRAME_BYTES(FRAME_BYTES)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_bank (push_bank),
    .push_len  (push_len),
    .pop       (pop),
    .q_full    (q_full),
    .q_empty   (q_empty),
    .head_bank (head_bank),
    .head_len  (head_len)
  );

  rsfd_store #(.FRAME_BYTES(FRAME_BYTES)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (frame_byte)
  );

  rsfd_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .head_bank    (head_bank),
    .head_len     (head_len),
    .pop          (pop),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_length (frame_length),
    .last         (last)
  );

endmodule

### rtl/core/rsfd_store.sv
// two-bank frame byte store with one write port and one registered read port
`timescale 1ns / 1ps

module rsfd_store import rsfd_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [$clog2(FRAME_BYTES):0]        wr_addr,
  input  logic [BYTE_W-1:0]                   wr_data,
  input  logic                                rd_en,
  input  logic [$clog2(FRAME_BYTES):0]        rd_addr,
  output logic [BYTE_W-1:0]                   rd_data
);

  localparam int AW    = $clog2(FRAME_BYTES);
  localparam int DEPTH = 2 << AW;

  logic [BYTE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/rsfd_front.sv
// front end: accepts ticks and bytes, runs the silence timer and fills the store
`timescale 1ns / 1ps

module rsfd_front import rsfd_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic                                  cfg_index,
  input  logic [TICK_W-1:0]                     cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  func,
  input  logic [BYTE_W-1:0]                     rx_byte,
  input  logic                                  q_full,
  output logic                                  wr_en,
  output logic [$clog2(FRAME_BYTES):0]          wr_addr,
  output logic [BYTE_W-1:0]                     wr_data,
  output logic                                  push,
  output logic                                  push_bank,
  output logic [$clog2(FRAME_BYTES+1)-1:0]      push_len
);

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int CW = $clog2(FRAME_BYTES + 1);

  typedef enum logic [1:0] {
    IDLE,
    RECEIVING,
    WAITING,
    WAITING_INVALID
  } mode_t;

  mode_t             mode, mode_next;
  logic [TICK_W-1:0] silence_count, silence_count_next;
  logic [CW-1:0]     byte_count, byte_count_next;
  logic              bank, bank_next;
  logic [TICK_W-1:0] gap_ticks, confirm_ticks;
  logic [TICK_W-1:0] sc_inc, compare;
  logic              expire, accept;

  // input held off only while both banks wait for readout
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // one-shot timer compare
  assign sc_inc  = silence_count + TICK_W'(1);
  assign compare = (mode == RECEIVING) ? gap_ticks : confirm_ticks;
  assign expire  = (sc_inc >= compare);

  assign wr_data  = rx_byte;
  assign push_bank = bank;
  assign push_len  = byte_count;

  // mode and store control
  always_comb begin
    mode_next          = mode;
    silence_count_next = silence_count;
    byte_count_next    = byte_count;
    bank_next          = bank;
    wr_en              = 1'b0;
    wr_addr            = {bank, byte_count[AW-1:0]};
    push               = 1'b0;
    if (accept) begin
      if (func == FUNC_BYTE) begin
        case (mode)
          IDLE: begin
            wr_en              = 1'b1;
            wr_addr            = {bank, AW'(0)};
            byte_count_next    = CW'(1);
            silence_count_next = '0;
            mode_next          = RECEIVING;
          end
          RECEIVING: begin
            if (byte_count < CW'(FRAME_BYTES)) begin
              wr_en           = 1'b1;
              byte_count_next = byte_count + CW'(1);
            end
            silence_count_next = '0;
          end
          default: begin
            mode_next = WAITING_INVALID;
          end
        endcase
      end else begin
        case (mode)
          RECEIVING: begin
            if (expire) begin
              mode_next          = WAITING;
              silence_count_next = '0;
            end else begin
              silence_count_next = sc_inc;
            end
          end
          WAITING: begin
            if (expire) begin
              push               = 1'b1;
              bank_next          = !bank;
              mode_next          = IDLE;
              byte_count_next    = '0;
              silence_count_next = '0;
            end else begin
              silence_count_next = sc_inc;
            end
          end
          WAITING_INVALID: begin
            if (expire) begin
              mode_next          = IDLE;
              byte_count_next    = '0;
              silence_count_next = '0;
            end else begin
              silence_count_next = sc_inc;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= IDLE;
      silence_count <= '0;
      byte_count    <= '0;
      bank          <= 1'b0;
      gap_ticks     <= GAP_TICKS_RST;
      confirm_ticks <= CONFIRM_TICKS_RST;
    end else begin
      mode          <= mode_next;
      silence_count <= silence_count_next;
      byte_count    <= byte_count_next;
      bank          <= bank_next;
      if (cfg_we && cfg_index == CFG_GAP_TICKS) begin
        gap_ticks <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_CONFIRM_TICKS) begin
        confirm_ticks <= cfg_data;
      end
    end
  end

endmodule

### rtl/core/rsfd_queue.sv
// two-entry queue of finished frames (bank and length) between front and back
`timescale 1ns / 1ps

module rsfd_queue import rsfd_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  logic                              push_bank,
  input  logic [$clog2(FRAME_BYTES+1)-1:0]  push_len,
  input  logic                              pop,
  output logic                              q_full,
  output logic                              q_empty,
  output logic                              head_bank,
  output logic [$clog2(FRAME_BYTES+1)-1:0]  head_len
);

  localparam int CW = $clog2(FRAME_BYTES + 1);

  logic          bank_q [2];
  logic [CW-1:0] len_q  [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    count;

  assign q_full    = (count == 2'd2);
  assign q_empty   = (count == 2'd0);
  assign head_bank = bank_q[rd_ptr];
  assign head_len  = len_q[rd_ptr];

  // entry payload
  always_ff @(posedge clk) begin
    if (push) begin
      bank_q[wr_ptr] <= push_bank;
      len_q[wr_ptr]  <= push_len;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/rsfd_back.sv
// back end: reads a finished frame out of the store, one byte per request
`timescale 1ns / 1ps

module rsfd_back import rsfd_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_empty,
  input  logic                              head_bank,
  input  logic [$clog2(FRAME_BYTES+1)-1:0]  head_len,
  output logic                              pop,
  output logic                              rd_en,
  output logic [$clog2(FRAME_BYTES):0]      rd_addr,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [LEN_W-1:0]                  frame_length,
  output logic                              last
);

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int CW = $clog2(FRAME_BYTES + 1);

  logic [AW-1:0] rd_idx;
  logic          at_end;

  // advance when a frame is queued and the output slot frees up
  assign rd_en   = !q_empty && (!out_valid || out_ready);
  assign rd_addr = {head_bank, rd_idx};
  assign at_end  = ((CW'(rd_idx) + CW'(1)) == head_len);
  assign pop     = rd_en && at_end;

  // read index and output register (byte value sits in the store read register)
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rd_en) begin
        out_valid <= 1'b1;
        rd_idx    <= at_end ? AW'(0) : rd_idx + AW'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      frame_length <= LEN_W'(head_len);
      last         <= at_end;
    end
  end

endmodule

### rtl/core/rsfd_checker.sv
// port-level checks on frame readout, bound to the top level
`timescale 1ns / 1ps

module rsfd_checker import rsfd_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] frame_byte,
  input logic [LEN_W-1:0]  frame_length,
  input logic              last
);

  logic [LEN_W-1:0] beat_count;

  // bytes delivered so far in the current frame
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_count <= '0;
    end else if (out_valid && out_ready) begin
      beat_count <= last ? LEN_W'(0) : beat_count + LEN_W'(1);
    end
  end

  // nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_byte) &&
      $stable(frame_length) && $stable(last))
    else $error("stalled result changed");

  // the last mark comes on the byte that completes the stated length
  a_last_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> (beat_count + LEN_W'(1)) == frame_length)
    else $error("last mark does not match frame length");

  // length stays the same across the bytes of one frame
  a_len_steady: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> !out_valid ||
      frame_length == $past(frame_length))
    else $error("frame length changed inside a frame");

endmodule

bind rtu_silence_frame_delimiter_top rsfd_checker u_rsfd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .frame_byte   (frame_byte),
  .frame_length (frame_length),
  .last         (last)
);

### tb/tb.sv
// testbench for the silence-delimited frame receiver top level
`timescale 1ns / 1ps

module tb;
  import rsfd_pkg::*;

  localparam int LATENCY_PAD      = 32;
  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int N_DIR            = 19;
  localparam int N_PHASES         = 4;
  localparam int HB_AW            = $clog2(FRAME_BYTES_DEF);

  typedef enum logic [1:0] {LINE_IDLE, LINE_RX, LINE_WAIT, LINE_WAIT_BAD} line_mode_t;
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
    logic              lst;
  } frame_beat_t;

  // directed row: for a timing row, data is gap_ticks and conf is confirm_ticks
  typedef struct packed {
    row_kind_t   kind;
    logic        f;
    logic [7:0]  data;
    logic [7:0]  conf;
    logic [7:0]  reps;
    logic        rnd;
    logic        scripted;
    logic [1:0]  n_exp;
    logic [7:0]  e0;
    logic [7:0]  e1;
  } stim_row_t;

  typedef struct packed {
    logic [7:0]  gap;
    logic [7:0]  conf;
    logic [15:0] quota;
  } timing_phase_t;

  localparam stim_row_t DIR_ROWS [N_DIR] = '{
    // reset timing: gap 21, confirm 29
    '{ROW_ITEM, FUNC_BYTE, 8'h00, 8'd0, 8'd1,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_ITEM, FUNC_TICK, 8'h00, 8'd0, 8'd20, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_ITEM, FUNC_BYTE, 8'hff, 8'd0, 8'd1,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_ITEM, FUNC_TICK, 8'h00, 8'd0, 8'd21, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_ITEM, FUNC_TICK, 8'h00, 8'd0, 8'd28, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_ITEM, FUNC_TICK, 8'h00, 8'd0, 8'd1,  1'b0, 1'b1, 2'd2, 8'h00, 8'hff},
    // tick while idle does nothing
    '{ROW_ITEM, FUNC_TICK, 8'h00, 8'd0, 8'd1,  1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_CFG,  FUNC_TICK, 8'd1,  8'd1, 8'd0,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    // byte during confirm wait drops the frame
    '{ROW_ITEM, FUNC_BYTE, 8'ha5, 8'd0, 8'd1,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_ITEM, FUNC_TICK, 8'h00, 8'd0, 8'd1,  1'b1, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_ITEM, FUNC_BYTE, 8'h5a, 8'd0, 8'd1,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_ITEM, FUNC_BYTE, 8'h3c, 8'd0, 8'd1,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_ITEM, FUNC_TICK, 8'h00, 8'd0, 8'd1,  1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
    // store overflow, bytes past the end are dropped
    '{ROW_ITEM, FUNC_BYTE, 8'h00, 8'd0, 8'd66, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_ITEM, FUNC_TICK, 8'h00, 8'd0, 8'd1,  1'b1, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_ITEM, FUNC_TICK, 8'h00, 8'd0, 8'd1,  1'b1, 1'b0, 2'd0, 8'h00, 8'h00},
    // single byte frame
    '{ROW_ITEM, FUNC_BYTE, 8'h81, 8'd0, 8'd1,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_ITEM, FUNC_TICK, 8'h00, 8'd0, 8'd1,  1'b1, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_ITEM, FUNC_TICK, 8'h00, 8'd0, 8'd1,  1'b0, 1'b1, 2'd1, 8'h81, 8'h00}
  };

  localparam timing_phase_t PHASES [N_PHASES] = '{
    '{8'd1,   8'd1,   16'd50},
    '{8'd3,   8'd2,   16'd50},
    '{8'd7,   8'd5,   16'd40},
    '{8'd12,  8'd9,   16'd35}
  };

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic              cfg_index;
  logic [TICK_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic              func;
  logic [BYTE_W-1:0] rx_byte;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] frame_byte;
  logic [LEN_W-1:0]  frame_length;
  logic              last;
  logic              in_scripted;

  // predictor state
  line_mode_t        line_mode;
  logic [7:0]        sil_cnt;
  bit                tmr_run;
  bit                tmr_exp;
  logic [LEN_W-1:0]  held_cnt;
  logic [7:0]        held_bytes [FRAME_BYTES_DEF];
  logic [7:0]        gap_cfg;
  logic [7:0]        conf_cfg;
  frame_beat_t       frame_beats_q [$];

  int fails;
  int rx_events;
  int stall_cycles;
  int rdy_hold;
  int rdy_pick;
  bit steady;
  frame_beat_t want;

  rtu_silence_frame_delimiter_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_byte   (frame_byte),
    .frame_length (frame_length),
    .last         (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // silence timer of the predictor
  task automatic arm_silence();
    sil_cnt = 8'd0;
    tmr_run = 1'b1;
    tmr_exp = 1'b0;
  endtask

  task automatic silence_tick(input logic [7:0] limit);
    if (tmr_run) begin
      sil_cnt = sil_cnt + 8'd1;
      if (sil_cnt >= limit) begin
        tmr_exp = 1'b1;
        tmr_run = 1'b0;
      end
    end
  endtask

  task automatic line_idle();
    line_mode = LINE_IDLE;
    held_cnt  = '0;
    sil_cnt   = 8'd0;
    tmr_run   = 1'b0;
    tmr_exp   = 1'b0;
  endtask

  // next line state for one event; a completed frame goes to the expected queue
  task automatic line_step(input logic f, input logic [7:0] d, input bit record);
    frame_beat_t beat;
    if (f == FUNC_BYTE) begin
      case (line_mode)
        LINE_IDLE: begin
          held_bytes[0] = d;
          held_cnt = 7'd1;
          line_mode = LINE_RX;
          arm_silence();
        end
        LINE_RX: begin
          if (held_cnt < FRAME_BYTES_DEF) begin
            held_bytes[held_cnt[HB_AW-1:0]] = d;
            held_cnt = held_cnt + 7'd1;
          end
          arm_silence();
        end
        default: line_mode = LINE_WAIT_BAD;
      endcase
    end else begin
      case (line_mode)
        LINE_RX: begin
          silence_tick(gap_cfg);
          if (tmr_exp) begin
            line_mode = LINE_WAIT;
            arm_silence();
          end
        end
        LINE_WAIT: begin
          silence_tick(conf_cfg);
          if (tmr_exp) begin
            for (int i = 0; i < held_cnt; i++) begin
              beat.data = held_bytes[HB_AW'(i)];
              beat.len  = held_cnt;
              beat.lst  = (i == held_cnt - 1);
              if (record) frame_beats_q.push_back(beat);
            end
            line_idle();
          end
        end
        LINE_WAIT_BAD: begin
          silence_tick(conf_cfg);
          if (tmr_exp) line_idle();
        end
        default: ;
      endcase
    end
  endtask

  // monitor: config shadow, result check, prediction, watchdog
  always @(posedge clk) begin
    if (rst) begin
      gap_cfg  = GAP_TICKS_RST;
      conf_cfg = CONFIRM_TICKS_RST;
      line_idle();
      stall_cycles = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_GAP_TICKS) gap_cfg = cfg_data;
        else conf_cfg = cfg_data;
      end
      stall_cycles++;
      if (out_valid && out_ready) begin
        stall_cycles = 0;
        if (frame_beats_q.size() == 0) begin
          $error("unexpected frame byte %0h", frame_byte);
          fails++;
        end else begin
          want = frame_beats_q.pop_front();
          if (frame_byte !== want.data) begin
            $error("frame_byte: expected %0h, got %0h", want.data, frame_byte);
            fails++;
          end
          if (frame_length !== want.len) begin
            $error("frame_length: expected %0d, got %0d", want.len, frame_length);
            fails++;
          end
          if (last !== want.lst) begin
            $error("last: expected %0b, got %0b", want.lst, last);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) begin
        stall_cycles = 0;
        if (!(func == FUNC_TICK && line_mode == LINE_IDLE)) rx_events++;
        line_step(func, rx_byte, !in_scripted);
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // frame readout backpressure
  always @(posedge clk) begin
    if (rdy_hold != 0) begin
      rdy_hold--;
    end else begin
      rdy_pick = $urandom_range(0, 99);
      if (rdy_pick < 10) begin
        out_ready <= 1'b1;
        rdy_hold = $urandom_range(60, 200);
      end else if (rdy_pick < 60) begin
        out_ready <= 1'b1;
        rdy_hold = $urandom_range(0, 5);
      end else if (rdy_pick < 95) begin
        out_ready <= 1'b0;
        rdy_hold = $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b0;
        rdy_hold = $urandom_range(15, 40);
      end
    end
  end

  function automatic int pick_idle();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // silent ticks that keep a frame open, mostly few
  function automatic int pick_ticks(input int maxv);
    if (maxv <= 0) return 0;
    if ($urandom_range(0, 4) != 0) return $urandom_range(0, (maxv < 3) ? maxv : 3);
    return $urandom_range(0, maxv);
  endfunction

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  // one request on the input channel, held until taken
  task automatic send_item(input logic f, input logic [7:0] d, input bit scripted);
    int idle;
    idle = pick_idle();
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= f;
    rx_byte     <= d;
    in_scripted <= scripted;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_tick();
    send_item(FUNC_TICK, rand_byte(), 1'b0);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6)) send_item(1'($urandom_range(0, 1)), rand_byte(), 1'b0);
  endtask

  // one frame: bytes with short silences, then a clean end, an intruding byte or no end
  task automatic send_frame(input int gap, input int conf);
    int len;
    int r;
    int k;
    r = $urandom_range(0, 9);
    if (r < 8) len = $urandom_range(1, 8);
    else if (r == 8) len = $urandom_range(9, 63);
    else len = $urandom_range(64, 70);
    if (gap > 32 && len > 4) len = $urandom_range(1, 4);
    for (int i = 0; i < len; i++) begin
      send_item(FUNC_BYTE, rand_byte(), 1'b0);
      if (i != len - 1) repeat (pick_ticks(gap - 1)) send_tick();
    end
    r = $urandom_range(0, 9);
    if (r < 7) begin
      repeat (gap + conf) send_tick();
    end else if (r < 9) begin
      repeat (gap) send_tick();
      k = $urandom_range(0, conf - 1);
      repeat (k) send_tick();
      repeat ($urandom_range(1, 2)) send_item(FUNC_BYTE, rand_byte(), 1'b0);
      repeat (conf - k) send_tick();
    end else begin
      repeat (pick_ticks(gap - 1)) send_tick();
    end
  endtask

  // enough ticks to close any frame in progress
  task automatic flush_line(input int gap, input int conf);
    repeat (gap + conf) send_tick();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frame_beats_q.size() != 0) @(posedge clk);
  endtask

  task automatic settle_line();
    wait_drained();
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  task automatic set_timing(input logic [7:0] gap, input logic [7:0] conf);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GAP_TICKS;
    cfg_data  <= gap;
    @(posedge clk);
    cfg_index <= CFG_CONFIRM_TICKS;
    cfg_data  <= conf;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    stim_row_t     row;
    timing_phase_t ph;
    frame_beat_t   beat;
    int            base;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = CFG_GAP_TICKS;
    cfg_data    = '0;
    in_valid    = 1'b0;
    func        = FUNC_TICK;
    rx_byte     = '0;
    in_scripted = 1'b0;
    fails       = 0;
    rx_events   = 0;
    rdy_hold    = 0;
    steady      = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int r = 0; r < N_DIR; r++) begin
      row = DIR_ROWS[r];
      if (row.kind == ROW_CFG) begin
        settle_line();
        set_timing(row.data, row.conf);
      end else begin
        if (row.scripted) begin
          wait_drained();
          for (int k = 0; k < row.n_exp; k++) begin
            beat.data = (k == 0) ? row.e0 : row.e1;
            beat.len  = LEN_W'(row.n_exp);
            beat.lst  = (k == row.n_exp - 1);
            frame_beats_q.push_back(beat);
          end
        end
        repeat (row.reps) send_item(row.f, row.rnd ? rand_byte() : row.data, row.scripted);
      end
    end

    // random frames under several timings
    for (int p = 0; p < N_PHASES; p++) begin
      ph = PHASES[p];
      settle_line();
      set_timing(ph.gap, ph.conf);
      base = rx_events;
      while (rx_events - base < ph.quota) begin
        steady = ($urandom_range(0, 3) == 0);
        if (ph.quota > 1 && $urandom_range(0, 6) == 0) send_noise();
        else send_frame(ph.gap, ph.conf);
      end
      steady = 1'b0;
      flush_line(ph.gap, ph.conf);
    end

    settle_line();
    if (fails == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/core/rsfd_pkg.sv
rtl/core/rsfd_store.sv
rtl/core/rsfd_front.sv
rtl/core/rsfd_queue.sv
rtl/core/rsfd_back.sv
rtl/core/rtu_silence_frame_delimiter_top.sv
rtl/core/rsfd_checker.sv
tb/tb.sv
